/* rtl/core/grid_tile_bitmap_allocator_core_macros.svh */
// ----------------------------------------------------------------------------
// Grid tile bitmap allocator: assertion macros
// Concurrent assertion wrappers clocked on clk, used by the checker file.
// ----------------------------------------------------------------------------
`ifndef GRID_TILE_BITMAP_ALLOCATOR_CORE_MACROS_SVH
`define GRID_TILE_BITMAP_ALLOCATOR_CORE_MACROS_SVH

// property checked out of reset only
`define GTBA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error(msg);

// property checked at every edge, reset included
`define GTBA_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) \
	else $error(msg);

`endif

/* rtl/core/gtba_pkg.sv */
// ----------------------------------------------------------------------------
// Grid tile bitmap allocator package
// Sizes, codes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package gtba_pkg;

	localparam int MaxSide  = 16;
	localparam int MapDepth = MaxSide * MaxSide;
	localparam int IdxW     = $clog2(MapDepth);
	localparam int CntW     = $clog2(MapDepth + 1);
	localparam int SideW    = $clog2(MaxSide + 1);

	localparam int TpsW     = 5;
	localparam int SizeW    = 13;
	localparam int CoordW   = 16;
	localparam int TIdxW    = 10;
	localparam int ModeW    = 3;
	localparam int CfgIdxW  = 1;
	localparam int CfgDataW = 13;

	// map scanned one word per cycle
	localparam int ScanW    = MaxSide;
	localparam int NumWords = MapDepth / ScanW;
	localparam int ScanLW   = $clog2(ScanW);
	localparam int WcW      = IdxW - ScanLW;

	localparam int LinW     = CoordW + SideW + 1;
	localparam int OrgW     = IdxW + SizeW;
	localparam int DivCntW  = $clog2(CoordW);

	localparam logic [TpsW-1:0]  TpsReset  = 5'd16;
	localparam logic [SizeW-1:0] SizeReset = 13'd512;

	localparam logic [CfgIdxW-1:0] REG_TILES_PER_SIDE = 1'd0;
	localparam logic [CfgIdxW-1:0] REG_TILE_SIZE      = 1'd1;

	localparam logic [ModeW-1:0] MODE_ALLOC  = 3'd0;
	localparam logic [ModeW-1:0] MODE_FREE   = 3'd1;
	localparam logic [ModeW-1:0] MODE_INSERT = 3'd2;
	localparam logic [ModeW-1:0] MODE_QUERY  = 3'd3;
	localparam logic [ModeW-1:0] MODE_CLEAR  = 3'd4;

	typedef enum logic [1:0] {
		DIV_SRC_X,
		DIV_SRC_Y,
		DIV_SRC_IDX
	} div_src_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_A_SET,
		ST_A_DIV,
		ST_ORG,
		ST_X_GO,
		ST_X_DIV,
		ST_Y_GO,
		ST_Y_DIV,
		ST_IDX,
		ST_RD,
		ST_UPD,
		ST_WIPE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic     load_in;
		logic     scan_step;
		logic     div_start;
		div_src_t div_src;
		logic     cap_x;
		logic     cap_y;
		logic     cap_i;
		logic     idx_calc;
		logic     idx_query;
		logic     rd_bit;
		logic     map_set;
		logic     map_clr;
		logic     map_wipe;
		logic     org_calc;
		logic     res_load;
		logic     res_ok;
		logic     res_org;
	} cmd_t;

	typedef struct packed {
		logic scan_hit;
		logic scan_last;
		logic div_done;
		logic idx_ok;
		logic bit_used;
	} st_t;

endpackage

`default_nettype wire

/* rtl/core/gtba_div.sv */
// ----------------------------------------------------------------------------
// Iterative divider
// Restoring division, one quotient bit per cycle, shared by allocate, free and insert.
// ----------------------------------------------------------------------------
`default_nettype none

module gtba_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [gtba_pkg::CoordW-1:0] dividend,
	input  logic [gtba_pkg::SizeW-1:0]  divisor,
	output logic                        done,
	output logic [gtba_pkg::CoordW-1:0] quotient,
	output logic [gtba_pkg::SizeW-1:0]  remainder
);

	logic                         busy_q;
	logic                         done_q;
	logic [gtba_pkg::DivCntW-1:0] cnt_q;
	logic [gtba_pkg::SizeW-1:0]   rem_q;
	logic [gtba_pkg::CoordW-1:0]  quo_q;
	logic [gtba_pkg::SizeW-1:0]   dsr_q;

	logic [gtba_pkg::SizeW:0]     rem_sh;
	logic [gtba_pkg::SizeW:0]     rem_diff;
	logic                         q_bit;
	logic [gtba_pkg::SizeW-1:0]   rem_nxt;

	always_comb begin
		rem_sh   = {rem_q, quo_q[gtba_pkg::CoordW-1]};
		rem_diff = rem_sh - {1'b0, dsr_q};
		q_bit    = (rem_sh >= {1'b0, dsr_q});
		rem_nxt  = q_bit ? rem_diff[gtba_pkg::SizeW-1:0] : rem_sh[gtba_pkg::SizeW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + gtba_pkg::DivCntW'(1);
				if (cnt_q == gtba_pkg::DivCntW'(gtba_pkg::CoordW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_nxt;
			quo_q <= {quo_q[gtba_pkg::CoordW-2:0], q_bit};
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

/* rtl/core/gtba_datapath.sv */
// ----------------------------------------------------------------------------
// Allocator datapath
// Configuration, used map and count, first-free scan, index math and results.
// ----------------------------------------------------------------------------
`default_nettype none

module gtba_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [gtba_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [gtba_pkg::CfgDataW-1:0] cfg_data,
	input  logic [gtba_pkg::CoordW-1:0]   tile_x,
	input  logic [gtba_pkg::CoordW-1:0]   tile_y,
	input  logic [gtba_pkg::TIdxW-1:0]    tile_index,
	input  gtba_pkg::cmd_t                cmd,
	output gtba_pkg::st_t                 st,
	output logic                          ok,
	output logic [gtba_pkg::CoordW-1:0]   origin_x,
	output logic [gtba_pkg::CoordW-1:0]   origin_y,
	output logic [gtba_pkg::CntW-1:0]     used_count
);

	logic [gtba_pkg::TpsW-1:0]   tps_q;
	logic [gtba_pkg::SizeW-1:0]  tsize_q;
	logic [gtba_pkg::CoordW-1:0] x_q;
	logic [gtba_pkg::CoordW-1:0] y_q;
	logic [gtba_pkg::TIdxW-1:0]  tidx_q;

	logic [gtba_pkg::NumWords-1:0][gtba_pkg::ScanW-1:0] used_q;
	logic [gtba_pkg::CntW-1:0]   cnt_q;
	logic [gtba_pkg::WcW-1:0]    wcnt_q;
	logic [gtba_pkg::IdxW-1:0]   idx_q;
	logic                        idx_ok_q;
	logic                        bit_q;
	logic [gtba_pkg::CoordW-1:0] col_q;
	logic [gtba_pkg::CoordW-1:0] row_q;
	logic [gtba_pkg::CoordW-1:0] ox_q;
	logic [gtba_pkg::CoordW-1:0] oy_q;

	logic                        res_ok_q;
	logic [gtba_pkg::CoordW-1:0] res_x_q;
	logic [gtba_pkg::CoordW-1:0] res_y_q;
	logic [gtba_pkg::CntW-1:0]   res_cnt_q;

	logic [gtba_pkg::SideW-1:0]   side_eff;
	logic [2*gtba_pkg::SideW-1:0] tot_full;
	logic [gtba_pkg::CntW-1:0]    total;

	logic [gtba_pkg::ScanW-1:0]  scan_word;
	logic [gtba_pkg::ScanW-1:0]  free_v;
	logic [gtba_pkg::IdxW-1:0]   gidx;
	logic [gtba_pkg::ScanLW-1:0] hit_pos;
	logic [gtba_pkg::CntW-1:0]   next_base;

	logic [gtba_pkg::LinW-1:0]   lin_prod;
	logic [gtba_pkg::LinW-1:0]   lin;
	logic [gtba_pkg::LinW-1:0]   total_ext;
	logic                        coord_ok;
	logic                        query_ok;

	logic [gtba_pkg::OrgW-1:0]   size_o;
	logic [gtba_pkg::OrgW-1:0]   org_x;
	logic [gtba_pkg::OrgW-1:0]   org_y;

	logic [gtba_pkg::CoordW-1:0] div_dividend;
	logic [gtba_pkg::SizeW-1:0]  div_divisor;
	logic                        div_done;
	logic [gtba_pkg::CoordW-1:0] div_quo;
	logic [gtba_pkg::SizeW-1:0]  div_rem;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q   <= gtba_pkg::TpsReset;
			tsize_q <= gtba_pkg::SizeReset;
		end else if (cfg_we) begin
			case (cfg_index)
				gtba_pkg::REG_TILES_PER_SIDE: tps_q   <= cfg_data[gtba_pkg::TpsW-1:0];
				gtba_pkg::REG_TILE_SIZE:      tsize_q <= cfg_data[gtba_pkg::SizeW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		side_eff = (tps_q > gtba_pkg::TpsW'(gtba_pkg::MaxSide)) ?
			gtba_pkg::SideW'(gtba_pkg::MaxSide) : gtba_pkg::SideW'(tps_q);
		tot_full = {{gtba_pkg::SideW{1'b0}}, side_eff} * {{gtba_pkg::SideW{1'b0}}, side_eff};
		total    = tot_full[gtba_pkg::CntW-1:0];
	end

	// first-free scan over the current word; bits past the grid count as used
	always_comb begin
		scan_word = used_q[wcnt_q];
		gidx      = '0;
		for (int b = 0; b < gtba_pkg::ScanW; b++) begin
			gidx      = {wcnt_q, gtba_pkg::ScanLW'(b)};
			free_v[b] = ~scan_word[b] & ({1'b0, gidx} < total);
		end
	end

	always_comb begin
		hit_pos = '0;
		for (int b = gtba_pkg::ScanW - 1; b >= 0; b--) begin
			if (free_v[b]) hit_pos = gtba_pkg::ScanLW'(b);
		end
	end

	assign next_base = {1'b0, wcnt_q, {gtba_pkg::ScanLW{1'b0}}} +
		gtba_pkg::CntW'(gtba_pkg::ScanW);

	// row-major index; an out-of-grid column carries into the next row
	always_comb begin
		lin_prod  = {{(gtba_pkg::LinW - gtba_pkg::CoordW){1'b0}}, row_q} *
			{{(gtba_pkg::LinW - gtba_pkg::SideW){1'b0}}, side_eff};
		lin       = lin_prod + {{(gtba_pkg::LinW - gtba_pkg::CoordW){1'b0}}, col_q};
		total_ext = {{(gtba_pkg::LinW - gtba_pkg::CntW){1'b0}}, total};
		coord_ok  = (tsize_q != '0) && (lin < total_ext);
		query_ok  = {{(gtba_pkg::LinW - gtba_pkg::TIdxW){1'b0}}, tidx_q} < total_ext;
	end

	always_comb begin
		size_o = {{gtba_pkg::IdxW{1'b0}}, tsize_q};
		org_x  = {{gtba_pkg::SizeW{1'b0}}, col_q[gtba_pkg::IdxW-1:0]} * size_o;
		org_y  = {{gtba_pkg::SizeW{1'b0}}, row_q[gtba_pkg::IdxW-1:0]} * size_o;
	end

	always_comb begin
		case (cmd.div_src)
			gtba_pkg::DIV_SRC_X: begin
				div_dividend = x_q;
				div_divisor  = tsize_q;
			end
			gtba_pkg::DIV_SRC_Y: begin
				div_dividend = y_q;
				div_divisor  = tsize_q;
			end
			gtba_pkg::DIV_SRC_IDX: begin
				div_dividend = {{(gtba_pkg::CoordW - gtba_pkg::IdxW){1'b0}}, idx_q};
				div_divisor  = {{(gtba_pkg::SizeW - gtba_pkg::SideW){1'b0}}, side_eff};
			end
			default: begin
				div_dividend = x_q;
				div_divisor  = tsize_q;
			end
		endcase
	end

	gtba_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// map and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			cnt_q  <= '0;
			wcnt_q <= '0;
		end else begin
			if (cmd.load_in) wcnt_q <= '0;
			else if (cmd.scan_step) wcnt_q <= wcnt_q + gtba_pkg::WcW'(1);

			if (cmd.map_wipe) begin
				used_q <= '0;
				cnt_q  <= '0;
			end else if (cmd.map_set) begin
				used_q[idx_q[gtba_pkg::IdxW-1:gtba_pkg::ScanLW]][idx_q[gtba_pkg::ScanLW-1:0]] <= 1'b1;
				cnt_q <= cnt_q + gtba_pkg::CntW'(1);
			end else if (cmd.map_clr) begin
				used_q[idx_q[gtba_pkg::IdxW-1:gtba_pkg::ScanLW]][idx_q[gtba_pkg::ScanLW-1:0]] <= 1'b0;
				cnt_q <= cnt_q - gtba_pkg::CntW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			x_q    <= tile_x;
			y_q    <= tile_y;
			tidx_q <= tile_index;
		end

		if (cmd.scan_step && (|free_v)) begin
			idx_q <= {wcnt_q, hit_pos};
		end else if (cmd.idx_calc) begin
			idx_q    <= cmd.idx_query ? tidx_q[gtba_pkg::IdxW-1:0] : lin[gtba_pkg::IdxW-1:0];
			idx_ok_q <= cmd.idx_query ? query_ok : coord_ok;
		end

		if (cmd.rd_bit) begin
			bit_q <= used_q[idx_q[gtba_pkg::IdxW-1:gtba_pkg::ScanLW]][idx_q[gtba_pkg::ScanLW-1:0]];
		end

		if (cmd.cap_x) col_q <= div_quo;
		if (cmd.cap_y) row_q <= div_quo;
		if (cmd.cap_i) begin
			row_q <= div_quo;
			col_q <= {{(gtba_pkg::CoordW - gtba_pkg::SizeW){1'b0}}, div_rem};
		end

		if (cmd.org_calc) begin
			ox_q <= org_x[gtba_pkg::CoordW-1:0];
			oy_q <= org_y[gtba_pkg::CoordW-1:0];
		end

		if (cmd.res_load) begin
			res_ok_q  <= cmd.res_ok;
			res_x_q   <= cmd.res_org ? ox_q : '0;
			res_y_q   <= cmd.res_org ? oy_q : '0;
			res_cnt_q <= cnt_q;
		end
	end

	always_comb begin
		st.scan_hit  = |free_v;
		st.scan_last = (next_base >= total);
		st.div_done  = div_done;
		st.idx_ok    = idx_ok_q;
		st.bit_used  = bit_q;
	end

	assign ok         = res_ok_q;
	assign origin_x   = res_x_q;
	assign origin_y   = res_y_q;
	assign used_count = res_cnt_q;

endmodule

`default_nettype wire

/* rtl/core/gtba_ctrl.sv */
// ----------------------------------------------------------------------------
// Allocator controller
// Sequences each transaction through the datapath and owns both handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module gtba_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [gtba_pkg::ModeW-1:0] mode,
	output logic                       out_valid,
	input  logic                       out_ready,
	output gtba_pkg::cmd_t             cmd,
	input  gtba_pkg::st_t              st
);

	gtba_pkg::state_t           state_q;
	gtba_pkg::state_t           state_nxt;
	logic [gtba_pkg::ModeW-1:0] mode_q;
	logic                       ok_q;
	logic                       ok_set;
	logic                       out_valid_q;
	logic                       slot_free;

	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			gtba_pkg::ST_IDLE: begin
				if (in_valid) begin
					case (mode)
						gtba_pkg::MODE_ALLOC:  state_nxt = gtba_pkg::ST_SCAN;
						gtba_pkg::MODE_FREE:   state_nxt = gtba_pkg::ST_X_GO;
						gtba_pkg::MODE_INSERT: state_nxt = gtba_pkg::ST_X_GO;
						gtba_pkg::MODE_QUERY:  state_nxt = gtba_pkg::ST_IDX;
						gtba_pkg::MODE_CLEAR:  state_nxt = gtba_pkg::ST_WIPE;
						default:               state_nxt = gtba_pkg::ST_DONE;
					endcase
				end
			end
			gtba_pkg::ST_SCAN: begin
				if (st.scan_hit) state_nxt = gtba_pkg::ST_A_SET;
				else if (st.scan_last) state_nxt = gtba_pkg::ST_DONE;
			end
			gtba_pkg::ST_A_SET: state_nxt = gtba_pkg::ST_A_DIV;
			gtba_pkg::ST_A_DIV: if (st.div_done) state_nxt = gtba_pkg::ST_ORG;
			gtba_pkg::ST_ORG:   state_nxt = gtba_pkg::ST_DONE;
			gtba_pkg::ST_X_GO:  state_nxt = gtba_pkg::ST_X_DIV;
			gtba_pkg::ST_X_DIV: if (st.div_done) state_nxt = gtba_pkg::ST_Y_GO;
			gtba_pkg::ST_Y_GO:  state_nxt = gtba_pkg::ST_Y_DIV;
			gtba_pkg::ST_Y_DIV: if (st.div_done) state_nxt = gtba_pkg::ST_IDX;
			gtba_pkg::ST_IDX:   state_nxt = gtba_pkg::ST_RD;
			gtba_pkg::ST_RD:    state_nxt = gtba_pkg::ST_UPD;
			gtba_pkg::ST_UPD:   state_nxt = gtba_pkg::ST_DONE;
			gtba_pkg::ST_WIPE:  state_nxt = gtba_pkg::ST_DONE;
			gtba_pkg::ST_DONE:  if (slot_free) state_nxt = gtba_pkg::ST_IDLE;
			default:            state_nxt = gtba_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd    = '0;
		ok_set = 1'b0;
		case (state_q)
			gtba_pkg::ST_IDLE: cmd.load_in = in_valid;
			gtba_pkg::ST_SCAN: cmd.scan_step = 1'b1;
			gtba_pkg::ST_A_SET: begin
				cmd.map_set   = 1'b1;
				cmd.div_start = 1'b1;
				cmd.div_src   = gtba_pkg::DIV_SRC_IDX;
				ok_set        = 1'b1;
			end
			gtba_pkg::ST_A_DIV: begin
				cmd.div_src = gtba_pkg::DIV_SRC_IDX;
				cmd.cap_i   = st.div_done;
			end
			gtba_pkg::ST_ORG: cmd.org_calc = 1'b1;
			gtba_pkg::ST_X_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_src   = gtba_pkg::DIV_SRC_X;
			end
			gtba_pkg::ST_X_DIV: cmd.cap_x = st.div_done;
			gtba_pkg::ST_Y_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_src   = gtba_pkg::DIV_SRC_Y;
			end
			gtba_pkg::ST_Y_DIV: cmd.cap_y = st.div_done;
			gtba_pkg::ST_IDX: begin
				cmd.idx_calc  = 1'b1;
				cmd.idx_query = (mode_q == gtba_pkg::MODE_QUERY);
			end
			gtba_pkg::ST_RD: cmd.rd_bit = 1'b1;
			gtba_pkg::ST_UPD: begin
				case (mode_q)
					gtba_pkg::MODE_FREE: cmd.map_clr = st.idx_ok && st.bit_used;
					gtba_pkg::MODE_INSERT: begin
						cmd.map_set = st.idx_ok && !st.bit_used;
						ok_set      = st.idx_ok && !st.bit_used;
					end
					gtba_pkg::MODE_QUERY: ok_set = st.idx_ok && st.bit_used;
					default: ;
				endcase
			end
			gtba_pkg::ST_WIPE: cmd.map_wipe = 1'b1;
			gtba_pkg::ST_DONE: begin
				cmd.res_load = slot_free;
				cmd.res_ok   = ok_q;
				cmd.res_org  = ok_q && (mode_q == gtba_pkg::MODE_ALLOC);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= gtba_pkg::ST_IDLE;
			mode_q      <= gtba_pkg::MODE_ALLOC;
			ok_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load_in) begin
				mode_q <= mode;
				ok_q   <= 1'b0;
			end else if (ok_set) begin
				ok_q <= 1'b1;
			end
			if (cmd.res_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign in_ready  = (state_q == gtba_pkg::ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

/* rtl/core/grid_tile_bitmap_allocator_core.sv */
// ----------------------------------------------------------------------------
// Grid tile bitmap allocator
// First-fit tile allocator over a square grid with a used-bit map and count.
//
//   Channel | Handshake            | Payload
//   --------+----------------------+---------------------------------------
//   in      | in_valid / in_ready  | mode, tile_x, tile_y, tile_index
//   out     | out_valid / out_ready| ok, origin_x, origin_y, used_count
//   cfg     | cfg_we               | cfg_index, cfg_data
//
// One transaction at a time. Clear wipes the map, query tests one bit, allocate
// scans one 16-bit map word per cycle, and allocate, free and insert each run
// the shared divider, which makes one quotient bit per cycle.
// Reset clears the map and count at once; no sweep follows.
// The result register holds while out_ready is low; a new input is taken
// while a result waits, and its own result waits for that register.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_tile_bitmap_allocator_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [gtba_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [gtba_pkg::CfgDataW-1:0] cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [gtba_pkg::ModeW-1:0]    mode,
	input  logic [gtba_pkg::CoordW-1:0]   tile_x,
	input  logic [gtba_pkg::CoordW-1:0]   tile_y,
	input  logic [gtba_pkg::TIdxW-1:0]    tile_index,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          ok,
	output logic [gtba_pkg::CoordW-1:0]   origin_x,
	output logic [gtba_pkg::CoordW-1:0]   origin_y,
	output logic [gtba_pkg::CntW-1:0]     used_count
);

	gtba_pkg::cmd_t cmd;
	gtba_pkg::st_t  st;

	gtba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.st        (st)
	);

	gtba_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.tile_x     (tile_x),
		.tile_y     (tile_y),
		.tile_index (tile_index),
		.cmd        (cmd),
		.st         (st),
		.ok         (ok),
		.origin_x   (origin_x),
		.origin_y   (origin_y),
		.used_count (used_count)
	);

endmodule

`default_nettype wire

/* rtl/core/gtba_checker.sv */
// ----------------------------------------------------------------------------
// Allocator port checker
// Port-level assertions on the top level, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "grid_tile_bitmap_allocator_core_macros.svh"

module gtba_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic                        ok,
	input logic [gtba_pkg::CoordW-1:0] origin_x,
	input logic [gtba_pkg::CoordW-1:0] origin_y,
	input logic [gtba_pkg::CntW-1:0]   used_count
);

	`GTBA_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(ok) && $stable(origin_x) && $stable(origin_y) && $stable(used_count), "result changed while stalled")

	`GTBA_ASSERT(a_one_at_a_time, in_valid && in_ready |=> !in_ready, "input taken while busy")

	`GTBA_ASSERT(a_fail_origin, out_valid && !ok |-> origin_x == '0 && origin_y == '0, "origin on failed result")

	`GTBA_ASSERT(a_count_range, out_valid |-> used_count <= gtba_pkg::MapDepth, "used count past map size")

	`GTBA_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !out_valid, "result valid in reset")

endmodule

bind grid_tile_bitmap_allocator_core gtba_checker u_gtba_checker (.*);

`default_nettype wire
